// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the label cost engine.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SLCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slce assertion failed");

// Property checked on every rising edge, reset included.
`define SLCE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("slce assertion failed during or after reset");

`endif

// ===== hw/rtl/slce_pkg.sv =====
// Package of the saturated label cost engine: sizes, request codes, cost
// sentinels and the command record passed from the front end to the back end.
package slce_pkg;

    // Store sizes
    localparam int NUM_STATES  = 4096;
    localparam int LABEL_COUNT = 1024;
    localparam int QUEUE_DEPTH = 4;

    // Field widths
    localparam int REQ_W   = 3;
    localparam int STATE_W = 12;
    localparam int LABEL_W = 10;
    localparam int COST_W  = 32;

    // Memory address widths
    localparam int DIST_AW  = $clog2(NUM_STATES);
    localparam int LABEL_AW = $clog2(LABEL_COUNT);
    localparam int Q_AW     = $clog2(QUEUE_DEPTH);

    typedef logic [REQ_W-1:0] t_req;

    // Request codes
    localparam t_req REQ_LOAD_DIST = 3'd0;
    localparam t_req REQ_LOAD_COST = 3'd1;
    localparam t_req REQ_BEGIN_SYS = 3'd2;
    localparam t_req REQ_BEGIN_GRP = 3'd3;
    localparam t_req REQ_TRANS     = 3'd4;
    localparam t_req REQ_ASSIGN    = 3'd5;
    localparam t_req REQ_REDUCE    = 3'd6;

    // Result kinds
    localparam logic KIND_SATURATED = 1'b0;
    localparam logic KIND_REDUCED   = 1'b1;

    // Cost sentinels
    localparam logic signed [COST_W-1:0] COST_INF   = 32'sd2147483647;
    localparam logic signed [COST_W-1:0] COST_NINF  = -32'sd2147483647;
    localparam logic signed [COST_W-1:0] COST_UNSET = -32'sd1;

    // One classified request on its way to the back end
    typedef struct packed {
        t_req                      op;
        logic [STATE_W-1:0]        addr_a;
        logic [STATE_W-1:0]        addr_b;
        logic                      src_ok;
        logic                      tgt_ok;
        logic [LABEL_W-1:0]        label;
        logic signed [COST_W-1:0]  value;
    } t_cmd;

endpackage

// ===== hw/rtl/slce_if.sv =====
// Request and result channel interfaces of the label cost engine.
// Depends on slce_pkg for the field widths.
interface slce_req_if import slce_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic [STATE_W-1:0]        state_index;
    logic [STATE_W-1:0]        src_state;
    logic [STATE_W-1:0]        target_state;
    logic [LABEL_W-1:0]        label_index;
    logic signed [COST_W-1:0]  value;

    modport source (
        output valid, req_type, state_index, src_state, target_state,
               label_index, value,
        input  ready
    );
    modport sink (
        input  valid, req_type, state_index, src_state, target_state,
               label_index, value,
        output ready
    );
endinterface

interface slce_res_if import slce_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      result_kind;
    logic [LABEL_W-1:0]        result_label;
    logic signed [COST_W-1:0]  result_cost;

    modport source (
        output valid, result_kind, result_label, result_cost,
        input  ready
    );
    modport sink (
        input  valid, result_kind, result_label, result_cost,
        output ready
    );
endinterface

// ===== hw/rtl/slce_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Self-contained; used for every store of the label cost engine.
module slce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/slce_front.sv =====
// Front end of the label cost engine: accepts requests, drops those that
// change nothing, and queues the rest as commands. Depends on slce_pkg.
module slce_front import slce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slce_req_if.sink    i_req,
    input  logic        i_init_busy,
    output t_cmd        o_cmd,
    output logic        o_cmd_valid,
    input  logic        i_cmd_pop
);

    t_cmd              cmd;
    logic              keep;
    logic              label_ok;
    logic              push;
    t_cmd              r_q [QUEUE_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    assign label_ok = 32'(i_req.label_index) < LABEL_COUNT;

    // Classify the request and build its command.
    always_comb begin
        cmd.op     = i_req.req_type;
        cmd.addr_a = (i_req.req_type == REQ_LOAD_DIST) ? i_req.state_index
                                                       : i_req.src_state;
        cmd.addr_b = i_req.target_state;
        cmd.src_ok = 32'(i_req.src_state) < NUM_STATES;
        cmd.tgt_ok = 32'(i_req.target_state) < NUM_STATES;
        cmd.label  = i_req.label_index;
        cmd.value  = i_req.value;
        case (i_req.req_type)
            REQ_LOAD_DIST: keep = 32'(i_req.state_index) < NUM_STATES;
            REQ_LOAD_COST: keep = label_ok;
            REQ_ASSIGN:    keep = label_ok;
            REQ_REDUCE:    keep = label_ok;
            REQ_BEGIN_SYS: keep = 1'b1;
            REQ_BEGIN_GRP: keep = 1'b1;
            REQ_TRANS:     keep = 1'b1;
            default:       keep = 1'b0;
        endcase
    end

    // Requests are taken while the queue has room and the first clearing
    // pass after reset has finished.
    assign i_req.ready = (r_count != (Q_AW+1)'(QUEUE_DEPTH)) && !i_init_busy;
    assign push        = i_req.valid && i_req.ready && keep;

    // Command queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_cmd_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_cmd_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_cmd       = r_q[r_rd_ptr];
    assign o_cmd_valid = (r_count != '0);

endmodule

// ===== hw/rtl/slce_back.sv =====
// Back end of the label cost engine: owns the stores, the group maximum and
// the result register, and carries out one queued command at a time.
// Depends on slce_pkg and slce_ram.
module slce_back import slce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    output logic        o_init_busy,
    slce_res_if.source  o_res
);

    localparam int SAT_W = COST_W + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_TR_RD  = 3'd2;
    localparam logic [2:0] ST_TR_MAX = 3'd3;
    localparam logic [2:0] ST_RED_RD = 3'd4;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic                      r_init;
    logic [LABEL_AW-1:0]       r_clr_addr;
    logic signed [COST_W-1:0]  r_group_max;
    logic signed [COST_W-1:0]  r_diff;
    logic signed [COST_W-1:0]  n_diff;
    t_cmd                      r_cmd;
    logic                      r_out_valid;
    logic                      r_out_kind;
    logic [LABEL_W-1:0]        r_out_label;
    logic signed [COST_W-1:0]  r_out_cost;

    logic                      slot_free;
    logic                      clearing;
    logic                      dist_we;
    logic                      tr_rd;
    logic                      cost_load;
    logic                      red_rd;
    logic                      red_wr;
    logic                      sat_assign;
    logic                      grp_clr;
    logic                      sys_begin;

    logic [COST_W-1:0]         dist_src_q;
    logic [COST_W-1:0]         dist_tgt_q;
    logic [COST_W-1:0]         rem_q;
    logic [SAT_W-1:0]          sat_q;

    logic                      rem_we;
    logic [LABEL_AW-1:0]       rem_waddr;
    logic [COST_W-1:0]         rem_wdata;
    logic                      sat_we;
    logic [LABEL_AW-1:0]       sat_waddr;
    logic [SAT_W-1:0]          sat_wdata;

    logic signed [COST_W-1:0]  hs;
    logic signed [COST_W-1:0]  ht;
    logic signed [COST_W-1:0]  rem;
    logic signed [COST_W-1:0]  sat;
    logic signed [COST_W-1:0]  red_res;

    // Saturate a 33-bit difference to the finite cost range.
    function automatic logic signed [COST_W-1:0] clamp_cost(
        input logic signed [COST_W:0] v
    );
        logic signed [COST_W-1:0] c;
        if (v > $signed({COST_INF[COST_W-1], COST_INF})) begin
            c = COST_INF;
        end else if (v < $signed({COST_NINF[COST_W-1], COST_NINF})) begin
            c = COST_NINF;
        end else begin
            c = v[COST_W-1:0];
        end
        return c;
    endfunction

    assign slot_free = !r_out_valid || o_res.ready;

    // Command sequencer
    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        clearing   = 1'b0;
        dist_we    = 1'b0;
        tr_rd      = 1'b0;
        cost_load  = 1'b0;
        red_rd     = 1'b0;
        red_wr     = 1'b0;
        sat_assign = 1'b0;
        grp_clr    = 1'b0;
        sys_begin  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clearing = 1'b1;
                if (r_clr_addr == LABEL_AW'(LABEL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        REQ_LOAD_DIST: begin
                            o_cmd_pop = 1'b1;
                            dist_we   = 1'b1;
                        end
                        REQ_LOAD_COST: begin
                            o_cmd_pop = 1'b1;
                            cost_load = 1'b1;
                        end
                        REQ_BEGIN_SYS: begin
                            o_cmd_pop = 1'b1;
                            grp_clr   = 1'b1;
                            sys_begin = 1'b1;
                            n_state   = ST_CLEAR;
                        end
                        REQ_BEGIN_GRP: begin
                            o_cmd_pop = 1'b1;
                            grp_clr   = 1'b1;
                        end
                        REQ_TRANS: begin
                            o_cmd_pop = 1'b1;
                            tr_rd     = 1'b1;
                            n_state   = ST_TR_RD;
                        end
                        REQ_ASSIGN: begin
                            if (slot_free) begin
                                o_cmd_pop  = 1'b1;
                                sat_assign = 1'b1;
                            end
                        end
                        REQ_REDUCE: begin
                            if (slot_free) begin
                                o_cmd_pop = 1'b1;
                                red_rd    = 1'b1;
                                n_state   = ST_RED_RD;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_TR_RD: begin
                n_state = ST_TR_MAX;
            end
            ST_TR_MAX: begin
                n_state = ST_IDLE;
            end
            ST_RED_RD: begin
                red_wr  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Two copies of the distance store so that both ends of a transition
    // are read in the same cycle.
    slce_ram #(.WIDTH(COST_W), .DEPTH(NUM_STATES)) u_dist_src (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (i_cmd.addr_a[DIST_AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_re    (tr_rd),
        .i_raddr (i_cmd.addr_a[DIST_AW-1:0]),
        .o_rdata (dist_src_q)
    );

    slce_ram #(.WIDTH(COST_W), .DEPTH(NUM_STATES)) u_dist_tgt (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (i_cmd.addr_a[DIST_AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_re    (tr_rd),
        .i_raddr (i_cmd.addr_b[DIST_AW-1:0]),
        .o_rdata (dist_tgt_q)
    );

    // Remaining cost store: written by a load or by a reduce.
    assign rem_we    = cost_load || red_wr;
    assign rem_waddr = red_wr ? r_cmd.label[LABEL_AW-1:0] : i_cmd.label[LABEL_AW-1:0];
    assign rem_wdata = red_wr ? red_res : i_cmd.value;

    slce_ram #(.WIDTH(COST_W), .DEPTH(LABEL_COUNT)) u_rem (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (rem_waddr),
        .i_wdata (rem_wdata),
        .i_re    (red_rd),
        .i_raddr (i_cmd.label[LABEL_AW-1:0]),
        .o_rdata (rem_q)
    );

    // Saturated cost store with its valid bit on top; the clearing pass
    // zeroes every entry.
    assign sat_we    = clearing || sat_assign;
    assign sat_waddr = clearing ? r_clr_addr : i_cmd.label[LABEL_AW-1:0];
    assign sat_wdata = clearing ? '0 : {1'b1, r_group_max};

    slce_ram #(.WIDTH(SAT_W), .DEPTH(LABEL_COUNT)) u_sat (
        .i_clk   (i_clk),
        .i_we    (sat_we),
        .i_waddr (sat_waddr),
        .i_wdata (sat_wdata),
        .i_re    (red_rd),
        .i_raddr (i_cmd.label[LABEL_AW-1:0]),
        .o_rdata (sat_q)
    );

    // Transition difference with the infinity rules; a state outside the
    // store reads as distance zero.
    assign hs = r_cmd.src_ok ? $signed(dist_src_q) : '0;
    assign ht = r_cmd.tgt_ok ? $signed(dist_tgt_q) : '0;

    always_comb begin
        if (hs == COST_NINF || ht == COST_INF) begin
            n_diff = COST_NINF;
        end else if (hs == COST_INF || ht == COST_NINF) begin
            n_diff = COST_INF;
        end else begin
            n_diff = clamp_cost($signed({hs[COST_W-1], hs}) - $signed({ht[COST_W-1], ht}));
        end
    end

    // Reduce: an unassigned label counts as a saturated cost of minus one.
    assign rem = $signed(rem_q);
    assign sat = sat_q[COST_W] ? $signed(sat_q[COST_W-1:0]) : COST_UNSET;

    always_comb begin
        if (rem == COST_UNSET || rem == COST_INF) begin
            red_res = rem;
        end else if (sat == COST_NINF) begin
            red_res = COST_INF;
        end else begin
            red_res = clamp_cost($signed({rem[COST_W-1], rem}) - $signed({sat[COST_W-1], sat}));
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_init      <= 1'b1;
            r_clr_addr  <= '0;
            r_group_max <= COST_NINF;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                if (r_clr_addr == LABEL_AW'(LABEL_COUNT - 1)) begin
                    r_clr_addr <= '0;
                    r_init     <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end else if (sys_begin) begin
                r_clr_addr <= '0;
            end
            if (grp_clr) begin
                r_group_max <= COST_NINF;
            end else if (r_state == ST_TR_MAX && r_diff > r_group_max) begin
                r_group_max <= r_diff;
            end
            if (sat_assign || red_wr) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_TR_RD) begin
            r_diff <= n_diff;
        end
        if (sat_assign) begin
            r_out_kind  <= KIND_SATURATED;
            r_out_label <= i_cmd.label;
            r_out_cost  <= r_group_max;
        end else if (red_wr) begin
            r_out_kind  <= KIND_REDUCED;
            r_out_label <= r_cmd.label;
            r_out_cost  <= red_res;
        end
    end

    assign o_init_busy        = r_init;
    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_out_kind;
    assign o_res.result_label = r_out_label;
    assign o_res.result_cost  = r_out_cost;

endmodule

// ===== hw/rtl/saturated_label_cost_engine.sv =====
// Top level of the saturated label cost engine: front end with command
// queue, back end with the stores. Depends on slce_pkg, slce_if, slce_front,
// slce_back.
//
//   Channel  Direction  Contents
//   i_req    in         request type, state/label indices, distance or cost
//   o_res    out        result kind, label, saturated or reduced cost
//
// The back end takes one queued command at a time: a load, a begin group or
// an assign completes in the idle state, a reduce adds a read state and a
// transition runs registered distance read, difference, group maximum update.
// A begin system runs a clearing pass over the saturated store, one label a
// cycle; requests keep queueing meanwhile.
// After reset the same pass runs with i_req.ready low.
// A four-entry queue lets requests enter while the back end is busy or its
// result waits; assigns and reduces wait for a free result register.
module saturated_label_cost_engine import slce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slce_req_if.sink    i_req,
    slce_res_if.source  o_res
);

    t_cmd  cmd;
    logic  cmd_valid;
    logic  cmd_pop;
    logic  init_busy;

    // Request intake and queue
    slce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_init_busy (init_busy),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Command execution and results
    slce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_init_busy (init_busy),
        .o_res       (o_res)
    );

endmodule

// ===== hw/rtl/slce_checker.sv =====
// Port-level checks for the saturated label cost engine, bound to its top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module slce_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_res_kind,
    input  logic [9:0]  i_res_label,
    input  logic [31:0] i_res_cost
);

    logic res_stall;

    // A result is stalled while it is offered and not taken.
    assign res_stall = i_res_valid && !i_res_ready;

    // A result offered and not taken stays offered.
    `SLCE_ASSERT(a_res_hold, i_clk, i_rst_n, res_stall |=> i_res_valid)

    // A stalled result keeps its label and cost.
    `SLCE_ASSERT(a_res_stable, i_clk, i_rst_n, res_stall |=> $stable({i_res_kind, i_res_label, i_res_cost}))

    // Reset empties the result register and holds requests off for the clearing pass.
    `SLCE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_req_ready && !i_res_valid)

    // Every cost leaving the block is saturated, so the lowest word never appears.
    `SLCE_ASSERT(a_cost_saturated, i_clk, i_rst_n, i_res_valid |-> i_res_cost != 32'h8000_0000)

endmodule

bind saturated_label_cost_engine slce_checker u_slce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.result_kind),
    .i_res_label (o_res.result_label),
    .i_res_cost  (o_res.result_cost)
);
